@@ sv/sfd_pkg.sv @@
// Shared constants and types for the sensor frame deframer.
package sfd_pkg;

    localparam int SFD_SAMPLE_COUNT = 32;
    localparam int SFD_BYTE_W       = 8;
    localparam int SFD_VALUE_W      = 16;
    localparam int SFD_INDEX_W      = 5;
    localparam int SFD_IN_TDATA_W   = 8;
    localparam int SFD_OUT_TDATA_W  = 24;

    localparam logic [SFD_BYTE_W-1:0] SFD_HEAD_BYTE = 8'h00;
    localparam logic [SFD_BYTE_W-1:0] SFD_TAIL_BYTE = 8'h21;

    typedef struct packed {
        logic                   found;
        logic [SFD_VALUE_W-1:0] sample;
    } sfd_status_t;

endpackage

@@ sv/sfd_window.sv @@
// Byte window shift line, fill count and frame match detection.
module sfd_window #(
    parameter int SAMPLE_COUNT = sfd_pkg::SFD_SAMPLE_COUNT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic [sfd_pkg::SFD_BYTE_W-1:0]  rx_byte,
    input  logic                            pop,
    output sfd_pkg::sfd_status_t            status
);
    import sfd_pkg::*;

    localparam int FRAME_LEN = 2 * SAMPLE_COUNT + 5;
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FRAME_LEN);
    localparam logic [FILL_W-1:0] FILL_ALMOST = FILL_W'(FRAME_LEN - 1);

    logic [SFD_BYTE_W-1:0] window_reg  [FRAME_LEN];
    logic [SFD_BYTE_W-1:0] window_next [FRAME_LEN];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic                  match;

    // Test the window as it will be after this byte enters.
    assign match = in_accept &&
                   (fill_reg >= FILL_ALMOST) &&
                   (window_reg[1] == SFD_HEAD_BYTE) &&
                   (window_reg[2] == SFD_HEAD_BYTE) &&
                   (window_reg[FRAME_LEN-2] == SFD_TAIL_BYTE) &&
                   (window_reg[FRAME_LEN-1] == SFD_TAIL_BYTE) &&
                   (rx_byte == SFD_TAIL_BYTE);

    always_comb begin
        window_next = window_reg;
        if (pop) begin
            // Drop the two oldest bytes: the next sample moves into window positions 2 and 3.
            for (int i = 0; i < FRAME_LEN - 2; i++) begin
                window_next[i] = window_reg[i+2];
            end
            window_next[FRAME_LEN-2] = '0;
            window_next[FRAME_LEN-1] = '0;
        end else if (in_accept) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                window_next[i] = window_reg[i+1];
            end
            window_next[FRAME_LEN-1] = rx_byte;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (match) begin
            fill_next = '0;
        end else if (in_accept && (fill_reg != FILL_FULL)) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign status.found  = match;
    assign status.sample = {window_reg[3], window_reg[2]};

endmodule

@@ sv/sfd_emit.sv @@
// Sample sequencer and output register for a found frame.
module sfd_emit #(
    parameter int SAMPLE_COUNT = sfd_pkg::SFD_SAMPLE_COUNT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sfd_pkg::sfd_status_t             status,
    output logic                             busy,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sfd_pkg::SFD_VALUE_W-1:0]  m_value,
    output logic [sfd_pkg::SFD_INDEX_W-1:0]  m_index,
    output logic                             m_last
);
    import sfd_pkg::*;

    localparam logic [SFD_INDEX_W-1:0] LAST_IDX = SFD_INDEX_W'(SAMPLE_COUNT - 1);

    logic                   busy_reg;
    logic [SFD_INDEX_W-1:0] idx_reg;
    logic                   valid_reg;
    logic [SFD_VALUE_W-1:0] value_reg;
    logic [SFD_INDEX_W-1:0] index_reg;
    logic                   last_reg;
    logic                   load;
    logic                   load_last;

    assign load      = busy_reg && (!valid_reg || m_ready);
    assign load_last = (idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (status.found) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (load) begin
                busy_reg <= !load_last;
                idx_reg  <= load_last ? '0 : idx_reg + 1'b1;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg <= status.sample;
            index_reg <= idx_reg;
            last_reg  <= load_last;
        end
    end

    assign busy    = busy_reg;
    assign pop     = load;
    assign m_valid = valid_reg;
    assign m_value = value_reg;
    assign m_index = index_reg;
    assign m_last  = last_reg;

    a_no_frame_while_busy: assert property (
        @(posedge aclk) disable iff (!aresetn) busy_reg |-> !status.found
    ) else $error("frame found while samples still pending");

    a_last_index: assert property (
        @(posedge aclk) disable iff (!aresetn) (valid_reg && last_reg) |-> (index_reg == LAST_IDX)
    ) else $error("last sample flag on wrong index");

    a_found_starts: assert property (
        @(posedge aclk) disable iff (!aresetn) status.found |=> (busy_reg && idx_reg == '0)
    ) else $error("frame did not start emission");

    a_mid_frame_busy: assert property (
        @(posedge aclk) disable iff (!aresetn) (load && !load_last) |=> busy_reg
    ) else $error("emission ended early");

endmodule

@@ sv/sensor_frame_deframer.sv @@
// Top level of the sensor frame deframer.
//
// Input channel (s_): one received byte per item in s_tdata[7:0]. The bytes
// slide through a window of 2*SAMPLE_COUNT+5 bytes. When the window holds that
// many bytes since the last frame, starts with two 0x00 bytes and ends with
// three 0x21 bytes, a frame is found.
// Result channel (m_): a found frame yields SAMPLE_COUNT items, each a 16-bit
// little-endian sample from the payload with its index; m_tlast marks the last.
// Throughput: one input byte per cycle while no frame is being emitted. The
// closing trailer byte starts the sample sequencer, which loads the first
// sample into the output register; samples then leave at one per cycle while
// m_tready is high; s_tready stays low while the sequencer walks the window.
// The last sample sits in the output register while the next byte is taken.
// A stall on m_tready holds the current sample and delays the rest; the input
// is held off until the frame's last sample is loaded.
// Reset (aresetn low, synchronous) clears the window fill count and the output valid flag.
module sensor_frame_deframer #(
    parameter int SAMPLE_COUNT = sfd_pkg::SFD_SAMPLE_COUNT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sfd_pkg::SFD_IN_TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfd_pkg::SFD_OUT_TDATA_W-1:0] m_tdata,  // [15:0] sample_value,
                                                          // [20:16] sample_index
    output logic                                m_tlast   // last_sample
);
    import sfd_pkg::*;

    sfd_status_t            status;
    logic                   busy;
    logic                   pop;
    logic                   in_accept;
    logic [SFD_VALUE_W-1:0] m_value;
    logic [SFD_INDEX_W-1:0] m_index;

    assign s_tready  = !busy;
    assign in_accept = s_tvalid && s_tready;

    sfd_window #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_tdata[SFD_BYTE_W-1:0]),
        .pop       (pop),
        .status    (status)
    );

    sfd_emit #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .busy    (busy),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_value (m_value),
        .m_index (m_index),
        .m_last  (m_tlast)
    );

    assign m_tdata = {(SFD_OUT_TDATA_W - SFD_VALUE_W - SFD_INDEX_W)'(0), m_index, m_value};

endmodule
